@@ rtl/dmpd_pkg.sv @@
// ----------------------------------------------------------------------------
// dmpd_pkg
// Shared types, codes and helper functions for the dual motor PWM drive.
// ----------------------------------------------------------------------------
`default_nettype none

package dmpd_pkg;

	// default PWM period in ticks
	localparam int PERIOD_DEF = 100;

	// speed limits, signed percent
	localparam logic signed [7:0] SPEED_MAX = 8'sd100;
	localparam logic signed [7:0] SPEED_MIN = -8'sd100;

	// register reset value and map
	localparam logic [6:0] TURN_STEP_RST  = 7'd5;
	localparam int         APB_ADDR_W     = 3;
	localparam int         APB_DATA_W     = 32;
	localparam logic       REG_TURN_STEP  = 1'b0;

	// request codes
	typedef enum logic [2:0] {
		REQ_TICK       = 3'd0,
		REQ_GO         = 3'd1,
		REQ_STOP       = 3'd2,
		REQ_HALT       = 3'd3,
		REQ_TURN_LEFT  = 3'd4,
		REQ_TURN_RIGHT = 3'd5,
		REQ_NEUTRAL    = 3'd6
	} req_e;

	// bridge drive codes
	typedef enum logic [1:0] {
		DRV_COAST = 2'd0,
		DRV_FWD   = 2'd1,
		DRV_BACK  = 2'd2,
		DRV_BRAKE = 2'd3
	} drive_e;

	typedef struct packed {
		logic [2:0]        req_type;
		logic signed [7:0] left_cmd_speed;
		logic signed [7:0] right_cmd_speed;
	} in_item_t;

	typedef struct packed {
		logic [1:0]        left_drive;
		logic [1:0]        right_drive;
		logic signed [7:0] left_speed_now;
		logic signed [7:0] right_speed_now;
		logic              driving;
	} out_item_t;

	// saturate a commanded speed to +/-100
	function automatic logic signed [7:0] clamp_cmd(input logic signed [7:0] v);
		logic signed [7:0] r;
		r = v;
		if (v > SPEED_MAX) begin
			r = SPEED_MAX;
		end else if (v < SPEED_MIN) begin
			r = SPEED_MIN;
		end
		return r;
	endfunction

	// subtract the turn step, saturating at -100
	function automatic logic signed [7:0] sat_sub(input logic signed [7:0] v,
		input logic [6:0] step);
		logic signed [8:0] d;
		logic signed [7:0] r;
		d = $signed({v[7], v}) - $signed({2'b00, step});
		r = d[7:0];
		if (d < $signed({SPEED_MIN[7], SPEED_MIN})) begin
			r = SPEED_MIN;
		end
		return r;
	endfunction

	// bridge state from speed and phase
	function automatic logic [1:0] bridge(input logic act,
		input logic signed [7:0] spd, input logic [7:0] phase);
		logic [6:0] mag;
		logic [1:0] r;
		mag = spd[7] ? 7'(-spd) : spd[6:0];
		r   = DRV_COAST;
		if (!act) begin
			r = DRV_BRAKE;
		end else if ({1'b0, mag} > phase) begin
			r = spd[7] ? DRV_BACK : DRV_FWD;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/dmpd_cfg.sv @@
// ----------------------------------------------------------------------------
// dmpd_cfg
// APB register file holding the turn step.
// ----------------------------------------------------------------------------
`default_nettype none

module dmpd_cfg import dmpd_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready,
	output logic      [6:0]            turn_step
);

	logic [6:0] turn_step_q;
	logic       hit;

	// register index is the word address bit
	assign hit    = (paddr[2] == REG_TURN_STEP);
	assign pready = 1'b1;

	// register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turn_step_q <= TURN_STEP_RST;
		end else if (psel && penable && pwrite && hit) begin
			turn_step_q <= pwdata[6:0];
		end
	end

	// read back
	always_comb begin
		prdata = '0;
		if (hit) begin
			prdata = {{(APB_DATA_W-7){1'b0}}, turn_step_q};
		end
	end

	assign turn_step = turn_step_q;

endmodule

`default_nettype wire

@@ rtl/dmpd_core.sv @@
// ----------------------------------------------------------------------------
// dmpd_core
// Speed and PWM phase state, command decode and bridge drive decision.
// ----------------------------------------------------------------------------
`default_nettype none

module dmpd_core import dmpd_pkg::*; #(
	parameter int PERIOD = PERIOD_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire in_item_t   item,
	input  wire logic [6:0] turn_step,
	output out_item_t       result
);

	localparam int PH_W = $clog2(PERIOD);
	localparam logic [PH_W-1:0] PH_LAST = PH_W'(PERIOD - 1);

	logic signed [7:0] left_q, right_q, left_d, right_d;
	logic              active_q, active_d;
	logic [PH_W-1:0]   phase_q, phase_d, ph_now;
	logic              restart;

	// apply the command
	always_comb begin
		left_d   = left_q;
		right_d  = right_q;
		active_d = active_q;
		ph_now   = phase_q;
		restart  = 1'b0;
		case (req_e'(item.req_type))
			REQ_GO: begin
				left_d  = clamp_cmd(item.left_cmd_speed);
				right_d = clamp_cmd(item.right_cmd_speed);
				restart = 1'b1;
			end
			REQ_STOP: begin
				left_d  = '0;
				right_d = '0;
				restart = 1'b1;
			end
			REQ_HALT: begin
				left_d   = '0;
				right_d  = '0;
				active_d = 1'b0;
				ph_now   = '0;
			end
			REQ_TURN_LEFT: begin
				right_d = sat_sub(right_q, turn_step);
				restart = 1'b1;
			end
			REQ_TURN_RIGHT: begin
				left_d  = sat_sub(left_q, turn_step);
				restart = 1'b1;
			end
			REQ_NEUTRAL: begin
				if (left_q > right_q) begin
					right_d = left_q;
					restart = 1'b1;
				end else if (left_q < right_q) begin
					left_d  = right_q;
					restart = 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (restart) begin
			active_d = 1'b1;
			ph_now   = '0;
		end
	end

	// outputs from the updated state
	always_comb begin
		result.left_drive      = bridge(active_d, left_d, 8'(ph_now));
		result.right_drive     = bridge(active_d, right_d, 8'(ph_now));
		result.left_speed_now  = left_d;
		result.right_speed_now = right_d;
		result.driving         = active_d;
	end

	// phase advance with wrap, held at zero while halted
	always_comb begin
		phase_d = '0;
		if (active_d && ph_now != PH_LAST) begin
			phase_d = ph_now + 1'b1;
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			right_q  <= '0;
			active_q <= 1'b1;
			phase_q  <= '0;
		end else if (step) begin
			left_q   <= left_d;
			right_q  <= right_d;
			active_q <= active_d;
			phase_q  <= phase_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/dual_motor_pwm_drive.sv @@
// ----------------------------------------------------------------------------
// dual_motor_pwm_drive
// Two-channel direction and duty PWM drive for left and right H-bridges.
//
//   channel  | direction | handshake         | payload
//   ---------+-----------+-------------------+-----------------------
//   in       | input     | in_valid/in_stall | in_data  (in_item_t)
//   out      | output    | out_valid/out_stall | out_data (out_item_t)
//   apb      | slave     | psel/penable/pready | turn_step register
//
// One request per clock while out_stall is low: an accepted request sits in
// the input register, is evaluated combinationally against the speed and
// phase state and lands in the result register.
// out_stall holds the result register and backs up into in_stall.
// Reset clears speeds and phase and leaves the drive active at zero speed.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_motor_pwm_drive import dmpd_pkg::*; #(
	parameter int PERIOD = PERIOD_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire in_item_t              in_data,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output out_item_t                  out_data,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready
);

	logic       valid_s1;
	in_item_t   item_s1;
	logic       valid_s2;
	out_item_t  data_s2;
	out_item_t  result;
	logic [6:0] turn_step;
	logic       out_free, advance;

	// flow control
	assign out_free = !valid_s2 || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	dmpd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.turn_step (turn_step)
	);

	dmpd_core #(
		.PERIOD (PERIOD)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.item      (item_s1),
		.turn_step (turn_step),
		.result    (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

`default_nettype wire

@@ tb/tb_dual_motor_pwm_drive.sv @@
// ----------------------------------------------------------------------------
// tb_dual_motor_pwm_drive
// Self-checking bench for the dual motor PWM drive. A small predictor keeps
// the stored speeds, the PWM phase, the halt state and the turn step, and
// works out the expected bridge outputs for every accepted request. Directed
// commands cover saturation, halts, turns, neutral and unused codes. Random
// traffic then mixes commands with long tick runs that sweep the PWM cycle,
// under several idle and stall patterns and several turn step settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_dual_motor_pwm_drive import dmpd_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 300000;
	localparam logic [2:0] REQ_UNUSED = 3'd7;
	localparam logic [APB_ADDR_W-1:0] TURN_STEP_ADDR = APB_ADDR_W'(4 * REG_TURN_STEP);

	// tracks drive state and holds the outputs still owed by the block
	class drive_checker;
		int        left_spd;
		int        right_spd;
		int        pwm_pos;
		bit        running;
		int        step_amt;
		int        mismatches;
		out_item_t awaited_outputs[$];

		function new();
			left_spd   = 0;
			right_spd  = 0;
			pwm_pos    = 0;
			running    = 1'b1;
			step_amt   = TURN_STEP_RST;
			mismatches = 0;
		endfunction

		function int clip_pct(int v);
			if (v > 100) begin
				return 100;
			end
			if (v < -100) begin
				return -100;
			end
			return v;
		endfunction

		function drive_e bridge_state(int spd);
			if (!running) begin
				return DRV_BRAKE;
			end
			if (spd > pwm_pos) begin
				return DRV_FWD;
			end
			if (-spd > pwm_pos) begin
				return DRV_BACK;
			end
			return DRV_COAST;
		endfunction

		// apply one request and form the outputs it causes
		function out_item_t drive_after(in_item_t r);
			out_item_t o;
			bit        rst_pwm;
			rst_pwm = 1'b0;
			case (r.req_type)
				REQ_GO: begin
					left_spd  = clip_pct(r.left_cmd_speed);
					right_spd = clip_pct(r.right_cmd_speed);
					rst_pwm   = 1'b1;
				end
				REQ_STOP: begin
					left_spd  = 0;
					right_spd = 0;
					rst_pwm   = 1'b1;
				end
				REQ_HALT: begin
					left_spd  = 0;
					right_spd = 0;
					running   = 1'b0;
					pwm_pos   = 0;
				end
				REQ_TURN_LEFT: begin
					right_spd = clip_pct(right_spd - step_amt);
					rst_pwm   = 1'b1;
				end
				REQ_TURN_RIGHT: begin
					left_spd = clip_pct(left_spd - step_amt);
					rst_pwm  = 1'b1;
				end
				REQ_NEUTRAL: begin
					// raise the slower side, nothing at all when already equal
					if (left_spd > right_spd) begin
						right_spd = left_spd;
						rst_pwm   = 1'b1;
					end else if (left_spd < right_spd) begin
						left_spd = right_spd;
						rst_pwm  = 1'b1;
					end
				end
				default: begin
				end
			endcase
			if (rst_pwm) begin
				running = 1'b1;
				pwm_pos = 0;
			end
			o.left_drive      = bridge_state(left_spd);
			o.right_drive     = bridge_state(right_spd);
			o.left_speed_now  = 8'(left_spd);
			o.right_speed_now = 8'(right_spd);
			o.driving         = running;
			// phase advance after the outputs are formed
			if (running) begin
				pwm_pos = (pwm_pos + 1 >= PERIOD_DEF) ? 0 : pwm_pos + 1;
			end else begin
				pwm_pos = 0;
			end
			return o;
		endfunction

		function void note_request(in_item_t r);
			awaited_outputs.push_back(drive_after(r));
		endfunction

		function void cmp_field(string name, int exp_v, int got_v);
			if (exp_v != got_v) begin
				$display("%0t: %s expected %0d got %0d", $time, name, exp_v, got_v);
				mismatches++;
			end
		endfunction

		function void check_output(out_item_t got);
			out_item_t exp_o;
			if (awaited_outputs.size() == 0) begin
				$display("%0t: unexpected result, expected none got %p", $time, got);
				mismatches++;
				return;
			end
			exp_o = awaited_outputs.pop_front();
			cmp_field("left_drive", exp_o.left_drive, got.left_drive);
			cmp_field("right_drive", exp_o.right_drive, got.right_drive);
			cmp_field("left_speed_now", exp_o.left_speed_now, got.left_speed_now);
			cmp_field("right_speed_now", exp_o.right_speed_now, got.right_speed_now);
			cmp_field("driving", exp_o.driving, got.driving);
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	in_item_t              in_data;
	logic                  out_valid;
	logic                  out_stall;
	out_item_t             out_data;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	drive_checker tracker;
	int           send_idle_pct;
	int           stall_pct;
	int           hold_len;
	int           cycles;

	dual_motor_pwm_drive #(.PERIOD(PERIOD_DEF)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// clock
	always #1 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// receiver stalls, with an optional long hold-off
	always @(posedge clk) begin
		if (hold_len > 0) begin
			out_stall <= 1'b1;
			hold_len = hold_len - 1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// request and result monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				tracker.note_request(in_data);
			end
			if (out_valid && !out_stall) begin
				tracker.check_output(out_data);
			end
		end
	end

	function automatic in_item_t mk_req(logic [2:0] code, logic signed [7:0] l,
		logic signed [7:0] r);
		in_item_t q;
		q.req_type        = code;
		q.left_cmd_speed  = l;
		q.right_cmd_speed = r;
		return q;
	endfunction

	// mostly legal percent, sometimes any byte
	function automatic logic signed [7:0] pick_speed();
		int v;
		if ($urandom_range(9) == 0) begin
			v = $urandom_range(255);
		end else begin
			v = $urandom_range(200) - 100;
		end
		return 8'(v);
	endfunction

	// offer one request after a random gap, return at its acceptance edge
	task automatic send_request(input in_item_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= r;
		do @(posedge clk); while (in_stall);
	endtask

	// stop sending and wait for every owed result
	task automatic wait_all_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (tracker.awaited_outputs.size() != 0);
	endtask

	// register write, then read back
	task automatic set_turn_step(input logic [6:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= TURN_STEP_ADDR;
		pwdata  <= APB_DATA_W'(v);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tracker.step_amt = v;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		check_turn_step();
	endtask

	task automatic check_turn_step();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= TURN_STEP_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== APB_DATA_W'(tracker.step_amt)) begin
			$display("%0t: turn_step read expected %0d got %0d", $time,
				tracker.step_amt, prdata);
			tracker.mismatches++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// commands each followed by a tick run, short runs mostly
	task automatic run_traffic(input int n_items);
		int       sent;
		int       pick;
		int       ticks;
		in_item_t r;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(99);
			r    = mk_req(REQ_TICK, pick_speed(), pick_speed());
			if (pick < 35) begin
				r.req_type = REQ_GO;
			end else if (pick < 45) begin
				r.req_type = REQ_TURN_LEFT;
			end else if (pick < 55) begin
				r.req_type = REQ_TURN_RIGHT;
			end else if (pick < 65) begin
				r.req_type = REQ_NEUTRAL;
			end else if (pick < 72) begin
				r.req_type = REQ_STOP;
			end else if (pick < 79) begin
				r.req_type = REQ_HALT;
			end else if (pick < 82) begin
				r.req_type = REQ_UNUSED;
			end
			send_request(r);
			sent++;
			ticks = ($urandom_range(7) == 0) ? $urandom_range(60, 130) : $urandom_range(8);
			repeat (ticks) begin
				send_request(mk_req(REQ_TICK, pick_speed(), pick_speed()));
				sent++;
			end
		end
	endtask

	initial begin
		tracker       = new();
		clk           = 1'b0;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		in_data       = '0;
		out_stall     = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_len      = 0;
		cycles        = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset value of the register
		check_turn_step();

		// directed commands
		send_request(mk_req(REQ_TICK, -8'sd128, 8'sd127));
		send_request(mk_req(REQ_GO, 8'sd100, -8'sd100));
		send_request(mk_req(REQ_TICK, 8'sd0, 8'sd0));
		send_request(mk_req(REQ_GO, -8'sd128, 8'sd127));
		send_request(mk_req(REQ_GO, -8'sd101, 8'sd101));
		send_request(mk_req(REQ_GO, 8'sd1, -8'sd1));
		send_request(mk_req(REQ_TICK, 8'sd55, -8'sd55));
		send_request(mk_req(REQ_HALT, 8'sd20, 8'sd20));
		send_request(mk_req(REQ_HALT, 8'sd0, 8'sd0));
		send_request(mk_req(REQ_NEUTRAL, 8'sd0, 8'sd0));
		send_request(mk_req(REQ_TICK, 8'sd0, 8'sd0));
		send_request(mk_req(REQ_GO, 8'sd0, 8'sd0));
		send_request(mk_req(REQ_GO, 8'sd50, -8'sd30));
		send_request(mk_req(REQ_TURN_LEFT, -8'sd1, -8'sd1));
		send_request(mk_req(REQ_TURN_RIGHT, 8'sd0, 8'sd0));
		send_request(mk_req(REQ_NEUTRAL, 8'sd0, 8'sd0));
		send_request(mk_req(REQ_GO, -8'sd20, 8'sd60));
		send_request(mk_req(REQ_NEUTRAL, 8'sd0, 8'sd0));
		send_request(mk_req(REQ_NEUTRAL, 8'sd0, 8'sd0));
		send_request(mk_req(REQ_STOP, 8'sd90, 8'sd90));
		send_request(mk_req(REQ_UNUSED, -8'sd7, 8'sd7));
		send_request(mk_req(REQ_GO, -8'sd100, -8'sd99));
		send_request(mk_req(REQ_TURN_LEFT, 8'sd0, 8'sd0));
		send_request(mk_req(REQ_TURN_RIGHT, 8'sd0, 8'sd0));
		send_request(mk_req(REQ_GO, 8'sd99, 8'sd2));
		wait_all_results();

		// no idling, turn step of 100, long receiver hold-off
		set_turn_step(7'd100);
		hold_len = 400;
		run_traffic(350);
		wait_all_results();

		// sender mostly idle, zero turn step, a full drain halfway
		set_turn_step(7'd0);
		send_idle_pct = 84;
		run_traffic(175);
		wait_all_results();
		run_traffic(175);
		wait_all_results();

		// receiver mostly stalled, some mid-range step
		set_turn_step(7'($urandom_range(1, 99)));
		send_idle_pct = 0;
		stall_pct     = 84;
		run_traffic(350);
		wait_all_results();

		// light idling on both sides, back to the reset step
		set_turn_step(TURN_STEP_RST);
		send_idle_pct = 13;
		stall_pct     = 13;
		run_traffic(350);
		wait_all_results();
		stall_pct = 0;
		repeat (10) @(posedge clk);

		if (tracker.mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

@@ files.f @@
rtl/dmpd_pkg.sv
rtl/dmpd_cfg.sv
rtl/dmpd_core.sv
rtl/dual_motor_pwm_drive.sv
tb/tb_dual_motor_pwm_drive.sv
